FILE: hw/rtl/signed_int_to_decimal_ascii_macros.svh
// Assertion helpers shared by the RTL of the decimal text converter.
// Each helper compiles to nothing when NO_ASSERTIONS is defined.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define SITDA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define SITDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SITDA_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define SITDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/sitda_pkg.sv
`timescale 1ns / 1ps

package sitda_pkg;

    localparam int CHAR_BITS      = 8;
    localparam int DIGIT_BITS     = 4;
    // Binary bits consumed by each shift-and-correct stage.
    localparam int BITS_PER_STAGE = 4;

    localparam logic [CHAR_BITS-1:0]  ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_BITS-1:0]  ASCII_MINUS = 8'd45;
    localparam logic [DIGIT_BITS-1:0] DIGIT_FIVE  = 4'd5;
    localparam logic [DIGIT_BITS-1:0] DIGIT_THREE = 4'd3;
    localparam logic [DIGIT_BITS-1:0] DIGIT_NINE  = 4'd9;

endpackage

FILE: hw/rtl/signed_int_to_decimal_ascii.sv
// Path: a value passes from its accepted transaction through the magnitude stage, the
// conversion stages and the leading digit stage into the character output register.
// Throughput: one character per cycle while text_ready is high; a value has 1 to 11
// characters at 32 bits, all sent through the single character output register.
// Reset: rst_n clears every valid bit asynchronously; no clearing pass is needed.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_macros.svh"

module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           value_valid,
    output logic                           value_ready,
    input  logic signed [VALUE_BITS-1:0]   value,
    output logic                           text_valid,
    input  logic                           text_ready,
    output logic [sitda_pkg::CHAR_BITS-1:0] character,
    output logic                           last
);
    import sitda_pkg::*;

    // Decimal digits enough for any VALUE_BITS-bit magnitude (log10(2) rounded up).
    localparam int NDIG = (VALUE_BITS * 302) / 1000 + 1;
    localparam int BCDW = NDIG * DIGIT_BITS;
    localparam int IDXW = $clog2(NDIG);
    // Shift-and-add-three stages, each handling BITS_PER_STAGE binary bits.
    localparam int NSTG = (VALUE_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    // Pipeline registers: magnitude stage, conversion stages, leading digit stage.
    localparam int NP   = NSTG + 2;

    typedef struct packed {
        logic                  neg;
        logic [BCDW-1:0]       bcd;
        logic [VALUE_BITS-1:0] bin;
    } stg_t;

    // One block of the double-dabble conversion. Each binary bit first corrects
    // every decimal digit of five or more by three, then shifts the whole
    // BCD:binary word one place left. Bits beyond VALUE_BITS are skipped, so the
    // final stage may consume fewer bits than the others.
    function automatic stg_t dabble(stg_t a, int s);
        stg_t                  r;
        logic [DIGIT_BITS-1:0] dig;
        r = a;
        for (int j = 0; j < BITS_PER_STAGE; j++) begin
            if (s * BITS_PER_STAGE + j < VALUE_BITS) begin
                for (int d = 0; d < NDIG; d++) begin
                    dig = r.bcd[d*DIGIT_BITS +: DIGIT_BITS];
                    if (dig >= DIGIT_FIVE) begin
                        dig = dig + DIGIT_THREE;
                    end
                    r.bcd[d*DIGIT_BITS +: DIGIT_BITS] = dig;
                end
                r.bcd = {r.bcd[BCDW-2:0], r.bin[VALUE_BITS-1]};
                r.bin = {r.bin[VALUE_BITS-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    // True when every packed digit is a legal decimal digit.
    function automatic logic bcd_ok(logic [BCDW-1:0] b);
        logic ok;
        ok = 1'b1;
        for (int d = 0; d < NDIG; d++) begin
            if (b[d*DIGIT_BITS +: DIGIT_BITS] > DIGIT_NINE) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    logic [VALUE_BITS-1:0] val_u;
    logic [VALUE_BITS-1:0] mag;

    stg_t                  stg_reg  [NP];
    stg_t                  stg_next [NP];
    logic [NP-1:0]         stg_vld_reg;
    logic [NP-1:0]         free;

    logic [IDXW-1:0]       msd_reg;
    logic [IDXW-1:0]       msd_next;

    logic                  ser_vld_reg;
    logic                  ser_vld_next;
    logic                  ser_neg_reg;
    logic                  ser_neg_next;
    logic [IDXW-1:0]       ser_idx_reg;
    logic [IDXW-1:0]       ser_idx_next;
    logic [BCDW-1:0]       ser_bcd_reg;
    logic [DIGIT_BITS-1:0] ser_digit;
    logic                  ser_ready;
    logic                  ser_load;

    // The magnitude is taken as an unsigned number, so the most negative value
    // converts to its true magnitude rather than overflowing.
    assign val_u = value;
    assign mag   = val_u[VALUE_BITS-1] ? (~val_u + VALUE_BITS'(1)) : val_u;

    // Stage data. The leading digit stage passes the conversion through and
    // locates the most significant non-zero digit alongside it.
    always_comb
    begin
        stg_next[0].neg = val_u[VALUE_BITS-1];
        stg_next[0].bcd = '0;
        stg_next[0].bin = mag;
        for (int p = 1; p <= NSTG; p++) begin
            stg_next[p] = dabble(stg_reg[p-1], p - 1);
        end
        stg_next[NP-1] = stg_reg[NP-2];
    end

    always_comb
    begin
        msd_next = '0;
        for (int d = 1; d < NDIG; d++) begin
            if (stg_reg[NP-2].bcd[d*DIGIT_BITS +: DIGIT_BITS] != '0) begin
                msd_next = IDXW'(d);
            end
        end
    end

    // A stage may load when it is empty or when its own transaction moves on in
    // the same cycle, so a stall holds every stage without losing anything.
    always_comb
    begin
        free[NP-1] = !stg_vld_reg[NP-1] || ser_ready;
        for (int p = NP - 2; p >= 0; p--) begin
            free[p] = !stg_vld_reg[p] || free[p+1];
        end
    end

    assign value_ready = free[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stg_vld_reg <= '0;
        end
        else begin
            if (free[0]) begin
                stg_vld_reg[0] <= value_valid;
            end
            for (int p = 1; p < NP; p++) begin
                if (free[p]) begin
                    stg_vld_reg[p] <= stg_vld_reg[p-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int p = 0; p < NP; p++) begin
            if (free[p]) begin
                stg_reg[p] <= stg_next[p];
            end
        end
        if (free[NP-1]) begin
            msd_reg <= msd_next;
        end
    end

    // Character serialiser. It holds one converted value and walks it out: the
    // minus sign first when the value is negative, then the digits from the most
    // significant non-zero one down to the units. It takes the next value in the
    // very cycle that its final character is accepted.
    assign ser_digit  = ser_bcd_reg[ser_idx_reg*DIGIT_BITS +: DIGIT_BITS];
    assign text_valid = ser_vld_reg;
    assign character  = ser_neg_reg ? ASCII_MINUS
                      : ASCII_ZERO + {{(CHAR_BITS-DIGIT_BITS){1'b0}}, ser_digit};
    assign last       = !ser_neg_reg && (ser_idx_reg == '0);

    assign ser_ready  = !ser_vld_reg || (text_ready && last);
    assign ser_load   = stg_vld_reg[NP-1] && ser_ready;

    always_comb
    begin
        ser_vld_next = ser_vld_reg;
        ser_neg_next = ser_neg_reg;
        ser_idx_next = ser_idx_reg;
        if (ser_load) begin
            ser_vld_next = 1'b1;
            ser_neg_next = stg_reg[NP-1].neg;
            ser_idx_next = msd_reg;
        end
        else if (ser_vld_reg && text_ready) begin
            if (ser_neg_reg) begin
                ser_neg_next = 1'b0;
            end
            else if (ser_idx_reg == '0) begin
                ser_vld_next = 1'b0;
            end
            else begin
                ser_idx_next = ser_idx_reg - IDXW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ser_vld_reg <= 1'b0;
            ser_neg_reg <= 1'b0;
            ser_idx_reg <= '0;
        end
        else begin
            ser_vld_reg <= ser_vld_next;
            ser_neg_reg <= ser_neg_next;
            ser_idx_reg <= ser_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_load) begin
            ser_bcd_reg <= stg_reg[NP-1].bcd;
        end
    end

    // An accepted transaction always lands in the magnitude stage.
    `SITDA_ASSERT_NEXT(a_input_lands, clk, rst_n, value_valid && value_ready, stg_vld_reg[0])
    // The conversion never leaves a digit outside zero to nine.
    `SITDA_ASSERT_SAME(a_bcd_legal, clk, rst_n, stg_vld_reg[NP-1], bcd_ok(stg_reg[NP-1].bcd))
    // A freshly loaded value starts at a non-zero digit unless it is zero itself.
    `SITDA_ASSERT_NEXT(a_no_leading_zero, clk, rst_n, ser_load,
        (ser_idx_reg == '0) || (ser_digit != '0))
    // The digit pointer stays within the converted digits.
    `SITDA_ASSERT_SAME(a_idx_range, clk, rst_n, ser_vld_reg,
        ser_idx_reg <= IDXW'(NDIG - 1))

endmodule

FILE: test/tb_signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;

    import sitda_pkg::*;

    localparam int VALUE_BITS   = 32;
    localparam int RANDOM_ITEMS = 258;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLDOFF_LEN  = 400;
    localparam int DIR_ROWS     = 22;

    typedef struct packed {
        logic [CHAR_BITS-1:0] character;
        logic                 last;
    } text_char_t;

    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         value_valid = 1'b0;
    logic                         value_ready;
    logic signed [VALUE_BITS-1:0] value       = '0;
    logic                         text_valid;
    logic                         text_ready  = 1'b0;
    logic [CHAR_BITS-1:0]         character;
    logic                         last;

    text_char_t expected_text [$];
    int         error_count = 0;
    int         values_sent = 0;
    int         cycle_count = 0;
    int         burst_left  = 0;

    // Directed rows. A non-empty string is the text expected for that value;
    // an empty one leaves the expectation to the predictor.
    localparam logic [VALUE_BITS-1:0] DIR_VALUE [DIR_ROWS] = '{
        32'sd0, -32'sd1, 32'sd2147483647, 32'h8000_0000,
        32'sd1, 32'sd9, 32'sd10, -32'sd9, -32'sd10, 32'sd99, 32'sd100, -32'sd100,
        32'h8000_0001, 32'h7FFF_FFFE, 32'sd1000000000, 32'sd999999999,
        -32'sd999999999, 32'h5555_5555, 32'hAAAA_AAAA, 32'sd12345, -32'sd54321,
        32'sd1073741824
    };
    string dir_text [DIR_ROWS] = '{
        "0", "-1", "2147483647", "-2147483648",
        "", "", "", "", "", "", "", "",
        "", "", "", "", "", "", "", "", "", ""
    };

    signed_int_to_decimal_ascii #(
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .value       (value),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .character   (character),
        .last        (last)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Decimal text of a two's complement value, most significant character first.
    function automatic void predict_text(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS-1:0] magnitude;
        logic [CHAR_BITS-1:0]  digits [$];
        text_char_t            entry;
        magnitude = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
        do
        begin
            digits.push_front(ASCII_ZERO + CHAR_BITS'(magnitude % 10));
            magnitude = magnitude / 10;
        end
        while (magnitude != 0);
        if (v[VALUE_BITS-1])
        begin
            entry.character = ASCII_MINUS;
            entry.last      = 1'b0;
            expected_text.push_back(entry);
        end
        for (int i = 0; i < digits.size(); i++)
        begin
            entry.character = digits[i];
            entry.last      = (i == digits.size() - 1);
            expected_text.push_back(entry);
        end
    endfunction

    function automatic void push_literal_text(input string s);
        text_char_t entry;
        for (int i = 0; i < s.len(); i++)
        begin
            entry.character = s[i];
            entry.last      = (i == s.len() - 1);
            expected_text.push_back(entry);
        end
    endfunction

    // Random values spread over digit counts, powers of ten and the extremes,
    // with a share of raw 32-bit patterns so that every bit toggles.
    function automatic logic [VALUE_BITS-1:0] random_value();
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned magnitude;
        int              digit_count;
        logic [VALUE_BITS-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                v = $urandom;
            4, 5, 6:
            begin
                digit_count = $urandom_range(1, 10);
                lo = 1;
                for (int i = 1; i < digit_count; i++)
                    lo = lo * 10;
                hi = lo * 10 - 1;
                if (digit_count == 1)
                    lo = 0;
                if (hi > 64'd2147483647)
                    hi = 64'd2147483647;
                magnitude = lo + ({32'd0, $urandom} % (hi - lo + 1));
                v = VALUE_BITS'(magnitude);
                if ($urandom_range(0, 1) == 1)
                    v = ~v + 1'b1;
            end
            7:
            begin
                magnitude = 1;
                digit_count = $urandom_range(0, 9);
                for (int i = 0; i < digit_count; i++)
                    magnitude = magnitude * 10;
                magnitude = magnitude + $urandom_range(0, 2) - 1;
                v = VALUE_BITS'(magnitude);
                if ($urandom_range(0, 1) == 1)
                    v = ~v + 1'b1;
            end
            8:
            begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'h8000_0001;
                    3:       v = 32'h7FFF_FFFE;
                    default: v = '0;
                endcase
            end
            default:
                v = VALUE_BITS'($urandom_range(0, 18)) - VALUE_BITS'(9);
        endcase
        return v;
    endfunction

    // Offers one value and waits for its transaction. The sender runs in
    // bursts; at the end of a burst valid may drop for a random gap.
    task automatic offer_value(input logic [VALUE_BITS-1:0] v, input string text);
        int gap;
        value_valid <= 1'b1;
        value       <= v;
        @(posedge clk);
        while (!value_ready)
            @(posedge clk);
        if (text.len() == 0)
            predict_text(v);
        else
            push_literal_text(text);
        values_sent++;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(0, 24);
            gap        = $urandom_range(0, 12);
            if (gap != 0)
            begin
                value_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
        begin
            burst_left--;
        end
    endtask

    // Receiver: alternates between stretches of full rate, random stalls,
    // solid stalls and a toggling pattern. At set points it holds off for a
    // long stretch so that the block fills and stalls its input.
    initial
    begin
        int mode;
        int run_len;
        int next_holdoff;
        next_holdoff = DIR_ROWS + 20;
        @(posedge rst_n);
        forever
        begin
            if (values_sent >= next_holdoff)
            begin
                text_ready <= 1'b0;
                repeat (HOLDOFF_LEN) @(posedge clk);
                next_holdoff = next_holdoff + 140;
            end
            mode    = $urandom_range(0, 3);
            run_len = $urandom_range(1, 40);
            for (int i = 0; i < run_len; i++)
            begin
                case (mode)
                    0:       text_ready <= 1'b1;
                    1:       text_ready <= ($urandom_range(0, 1) == 1);
                    2:       text_ready <= (i >= run_len / 2);
                    default: text_ready <= i[0];
                endcase
                @(posedge clk);
            end
        end
    end

    // Every character transaction is compared with the oldest expectation.
    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && text_valid && text_ready)
        begin
            if (expected_text.size() == 0)
            begin
                $error("unexpected character %0d (last %0b)", character, last);
                error_count++;
            end
            else
            begin
                want = expected_text.pop_front();
                if (character !== want.character)
                begin
                    $error("character: expected %0d, got %0d", want.character, character);
                    error_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, last);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_signed_int_to_decimal_ascii NOT OK");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int row = 0; row < DIR_ROWS; row++)
            offer_value(DIR_VALUE[row], dir_text[row]);

        for (int n = 0; n < RANDOM_ITEMS; n++)
            offer_value(random_value(), "");

        value_valid <= 1'b0;
        while (expected_text.size() != 0)
            @(posedge clk);
        // Any stray character after the last expected one is caught here.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_text.size() == 0)
            $display("tb_signed_int_to_decimal_ascii OK");
        else
            $display("tb_signed_int_to_decimal_ascii NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/sitda_pkg.sv
hw/rtl/signed_int_to_decimal_ascii.sv
test/tb_signed_int_to_decimal_ascii.sv
